// File: sv/char_lcd_dirty_refresh_assert.svh
// Assertion macros shared by the character buffer RTL.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef CHAR_LCD_DIRTY_REFRESH_ASSERT_SVH
`define CHAR_LCD_DIRTY_REFRESH_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define CLDR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("char_lcd_dirty_refresh: same-cycle check failed");

// Consequence must hold in the cycle after the antecedent.
`define CLDR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("char_lcd_dirty_refresh: next-cycle check failed");

`endif

// File: sv/cldr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cldr_pkg;

    // Display geometry.
    localparam int COLUMNS = 20;
    localparam int ROWS    = 4;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);

    // Field widths fixed by the transaction format.
    localparam int ROW_W  = 2;
    localparam int COL_W  = 5;
    localparam int CHAR_W = 8;

    // Bus byte constants.
    localparam logic [7:0] SET_ADDRESS     = 8'h80;
    localparam logic [7:0] SECOND_ROW_BASE = 8'h40;
    localparam logic [7:0] ADDRESS_MASK    = 8'h7F;
    localparam logic [7:0] SPACE_CODE      = 8'h20;

    // Operation codes.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        logic [CHAR_W-1:0] character;
    } cmd_t;

    typedef struct packed {
        logic              is_data;
        logic [7:0]        bus_byte;
        logic              last;
    } lcd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CMD,
        ST_DATA
    } state_t;

    // Linear store address of a row and column.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(int'(row) * COLUMNS + int'(col));
    endfunction

    // Set-address command for a row and column.
    function automatic logic [7:0] set_address_cmd(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
        logic [7:0] base;
        base = 8'h00;
        if (row[0])
        begin
            base = base + SECOND_ROW_BASE;
        end
        if (row[1])
        begin
            base = base + 8'(COLUMNS);
        end
        return SET_ADDRESS | ((base + 8'(col)) & ADDRESS_MASK);
    endfunction

endpackage

`default_nettype wire

// File: sv/cldr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cldr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port, registered read port that holds when not read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/char_lcd_dirty_refresh.sv
`timescale 1ns / 1ps
`default_nettype none
// Shadow character buffer that sends a character display only what changed.
// Command channel (cmd_valid, cmd_stall, cmd): write one character, clear all
// entries to spaces, or flush one row. Write and clear produce nothing. A
// flush walks the row column by column; each pending column costs a store
// read and then one step per emitted byte. The store is a single-port-read
// RAM, and its read latency sets the walk.
// Output channel (lcd_valid, lcd_stall, lcd): one transaction per bus byte,
// a set-address command at the start of each run of pending columns, then
// data bytes; last marks the final byte of a flush. After a flush is
// accepted, the first byte goes through ST_SCAN, ST_CMD and out_reg.
// cmd_stall is high while a flush is running. A stalled output holds its
// transaction and the walk waits; the command channel is open again as soon
// as the walk ends, even while the last byte still waits to be taken.
// Reset is immediate: nothing is pending and no transaction is offered.
// Pending and written-since-clear flags sit in flip-flops, so a clear sets
// them all at once and no sweep of the RAM is needed.

`include "char_lcd_dirty_refresh_assert.svh"

module char_lcd_dirty_refresh (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_stall,
    input  wire cldr_pkg::cmd_t cmd,
    output logic                lcd_valid,
    input  wire logic           lcd_stall,
    output cldr_pkg::lcd_t      lcd
);

    cldr_pkg::state_t                    state_reg, state_next;
    logic [cldr_pkg::ROW_W-1:0]          row_reg, row_next;
    logic [cldr_pkg::COL_W-1:0]          col_reg, col_next;
    logic                                placed_reg, placed_next;
    logic [cldr_pkg::CELLS-1:0]          pend_reg, pend_next;
    logic [cldr_pkg::CELLS-1:0]          fresh_reg, fresh_next;
    cldr_pkg::lcd_t                      out_reg, out_next;
    logic                                out_valid_reg, out_valid_next;

    logic                                cmd_take;
    logic                                out_free;
    logic                                cmd_issue;
    logic                                last_col;
    logic                                more_after;
    logic                                write_ok;
    logic                                flush_ok;
    logic [cldr_pkg::ADDR_W-1:0]         cur_idx;
    logic [cldr_pkg::ADDR_W-1:0]         wr_idx;
    logic [7:0]                          char_value;

    logic                                ram_we;
    logic                                ram_re;
    logic [cldr_pkg::CHAR_W-1:0]         ram_rdata;

    // Handshake and address helpers.
    assign cmd_stall  = (state_reg != cldr_pkg::ST_IDLE);
    assign cmd_take   = cmd_valid && !cmd_stall;
    assign out_free   = !out_valid_reg || !lcd_stall;
    assign cmd_issue  = (state_reg == cldr_pkg::ST_CMD) && out_free;
    assign lcd_valid  = out_valid_reg;
    assign lcd        = out_reg;
    assign last_col   = (col_reg == cldr_pkg::COL_W'(cldr_pkg::COLUMNS - 1));
    assign cur_idx    = cldr_pkg::cell_addr(row_reg, col_reg);
    assign wr_idx     = cldr_pkg::cell_addr(cmd.row, cmd.column);
    assign write_ok   = (int'(cmd.row) < cldr_pkg::ROWS)
                        && (int'(cmd.column) < cldr_pkg::COLUMNS);
    assign flush_ok   = (int'(cmd.row) < cldr_pkg::ROWS);

    // Store access: writes only while idle, reads only while walking.
    assign ram_we     = cmd_take && (cmd.opcode == cldr_pkg::OP_WRITE) && write_ok;
    assign ram_re     = (state_reg == cldr_pkg::ST_SCAN) && pend_reg[cur_idx];

    // An entry not written since the last clear holds a space.
    assign char_value = fresh_reg[cur_idx] ? ram_rdata : cldr_pkg::SPACE_CODE;

    // Is anything pending to the right of the current column?
    always_comb
    begin
        more_after = 1'b0;
        for (int j = 0; j < cldr_pkg::COLUMNS; j++)
        begin
            if ((j > int'(col_reg))
                && pend_reg[cldr_pkg::cell_addr(row_reg, cldr_pkg::COL_W'(j))])
            begin
                more_after = 1'b1;
            end
        end
    end

    cldr_ram #(
        .WIDTH(cldr_pkg::CHAR_W),
        .DEPTH(cldr_pkg::CELLS)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(wr_idx),
        .wdata(cmd.character),
        .re   (ram_re),
        .raddr(cur_idx),
        .rdata(ram_rdata)
    );

    // Next state of the flush sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cldr_pkg::ST_IDLE:
            begin
                if (cmd_take && (cmd.opcode == cldr_pkg::OP_FLUSH) && flush_ok)
                begin
                    state_next = cldr_pkg::ST_SCAN;
                end
            end
            cldr_pkg::ST_SCAN:
            begin
                if (pend_reg[cur_idx])
                begin
                    state_next = placed_reg ? cldr_pkg::ST_DATA : cldr_pkg::ST_CMD;
                end
                else if (last_col)
                begin
                    state_next = cldr_pkg::ST_IDLE;
                end
            end
            cldr_pkg::ST_CMD:
            begin
                if (out_free)
                begin
                    state_next = cldr_pkg::ST_DATA;
                end
            end
            cldr_pkg::ST_DATA:
            begin
                if (out_free)
                begin
                    state_next = last_col ? cldr_pkg::ST_IDLE : cldr_pkg::ST_SCAN;
                end
            end
        endcase
    end

    // Datapath and flag updates for each state.
    always_comb
    begin
        row_next       = row_reg;
        col_next       = col_reg;
        placed_next    = placed_reg;
        pend_next      = pend_reg;
        fresh_next     = fresh_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && lcd_stall;
        unique case (state_reg)
            cldr_pkg::ST_IDLE:
            begin
                if (cmd_take)
                begin
                    unique case (cmd.opcode)
                        cldr_pkg::OP_WRITE:
                        begin
                            if (write_ok)
                            begin
                                pend_next[wr_idx]  = (cmd.character != '0);
                                fresh_next[wr_idx] = 1'b1;
                            end
                        end
                        cldr_pkg::OP_CLEAR:
                        begin
                            pend_next  = '1;
                            fresh_next = '0;
                        end
                        cldr_pkg::OP_FLUSH:
                        begin
                            row_next    = cmd.row;
                            col_next    = '0;
                            placed_next = 1'b0;
                        end
                        default:
                        begin
                            // Unused operation: nothing to do.
                        end
                    endcase
                end
            end
            cldr_pkg::ST_SCAN:
            begin
                if (!pend_reg[cur_idx])
                begin
                    placed_next = 1'b0;
                    if (!last_col)
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            cldr_pkg::ST_CMD:
            begin
                if (out_free)
                begin
                    out_next.is_data  = 1'b0;
                    out_next.bus_byte = cldr_pkg::set_address_cmd(row_reg, col_reg);
                    out_next.last     = 1'b0;
                    out_valid_next    = 1'b1;
                    placed_next       = 1'b1;
                end
            end
            cldr_pkg::ST_DATA:
            begin
                if (out_free)
                begin
                    out_next.is_data   = 1'b1;
                    out_next.bus_byte  = char_value;
                    out_next.last      = !more_after;
                    out_valid_next     = 1'b1;
                    pend_next[cur_idx] = 1'b0;
                    if (!last_col)
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cldr_pkg::ST_IDLE;
            placed_reg    <= 1'b0;
            pend_reg      <= '0;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            placed_reg    <= placed_next;
            pend_reg      <= pend_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        col_reg <= col_next;
        out_reg <= out_next;
    end

    // Checks on the sequencer and store access.
    `CLDR_ASSERT_NOW(a_data_pending, state_reg == cldr_pkg::ST_DATA, pend_reg[cur_idx])
    `CLDR_ASSERT_NOW(a_cmd_not_last, out_valid_reg && !out_reg.is_data, !out_reg.last)
    `CLDR_ASSERT_NOW(a_no_rw_clash, ram_re, !ram_we)
    `CLDR_ASSERT_NEXT(a_cmd_to_data, cmd_issue, state_reg == cldr_pkg::ST_DATA)

endmodule

`default_nettype wire
